// ----- rtl/core/tva_pkg.sv -----
// ----------------------------------------------------------------------------
// tva_pkg
// Shared types and constants of the timed voice allocator.
// ----------------------------------------------------------------------------
package tva_pkg;

	localparam int MAX_VOICES_DEF = 64;
	localparam int TIME_W         = 31;
	localparam int VOICE_W        = 6;
	localparam int COUNT_W        = 7;

	typedef struct packed {
		logic [TIME_W-1:0]  wait_time;
		logic               continues_voice;
		logic [VOICE_W-1:0] prior_voice;
		logic               reserved_later;
		logic               loads_graph;
		logic [TIME_W-1:0]  graph_time;
	} in_word_t;

	typedef struct packed {
		logic [VOICE_W-1:0] assigned_voice;
		logic               fresh_voice;
		logic               table_full;
		logic [COUNT_W-1:0] voices_in_use;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_COMMIT
	} state_t;

endpackage

// ----- rtl/core/tva_ram.sv -----
// ----------------------------------------------------------------------------
// tva_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tva_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/timed_voice_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// timed_voice_allocator_unit
// Assigns a voice to each timed event and ages all allocated voices.
// ----------------------------------------------------------------------------
// An event word is accepted only in the idle state. While the table is still
// empty it goes straight to commit; otherwise the voice memory is swept one
// entry per cycle through its single read port, over the N voices allocated
// before it (up to MAX_VOICES), each entry aged by the event's wait and
// written back while the first free voice is searched; the last write-back
// and a settling step follow the reads, then the commit state updates the
// chosen voice. The result sits in an
// output register, so the next event is taken and swept while the previous
// result still waits; its commit holds until that register is free.
// Entries above the allocated count are never read before being written,
// so the memory needs no clearing after reset.
module timed_voice_allocator_unit #(
	parameter int MAX_VOICES = tva_pkg::MAX_VOICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tva_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tva_pkg::out_word_t  out_data
);

	localparam int TW  = tva_pkg::TIME_W;
	localparam int VW  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int CW  = $clog2(MAX_VOICES + 1);
	localparam int PW  = (CW > tva_pkg::VOICE_W) ? CW : tva_pkg::VOICE_W;
	localparam int EW  = TW + 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VOICES);

	tva_pkg::state_t   state_q, state_d;
	tva_pkg::in_word_t item_q;
	tva_pkg::out_word_t out_q;
	logic              out_valid_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic          vld_s1;
	logic [VW-1:0] addr_s1;
	logic          found_q;
	logic [VW-1:0] found_idx_q;
	logic [TW-1:0] prior_time_q;

	logic          rd_done, rd_en, slot_free, commit;
	logic          ram_we;
	logic [VW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	logic [TW-1:0] cur_time, dec_time;
	logic          cur_resv;

	logic [PW-1:0] prior_w;
	logic          cont_ok, full;
	logic          fresh;
	logic [VW-1:0] voice;
	logic [TW-1:0] keep_time;
	logic [CW-1:0] count_d;

	tva_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_VOICES)
	) u_voice_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q[VW-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_done   = (rd_idx_q == count_q);
	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tva_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (count_q == '0) ? tva_pkg::ST_COMMIT : tva_pkg::ST_SWEEP;
				end
			end
			tva_pkg::ST_SWEEP: begin
				if (rd_done && !vld_s1) begin
					state_d = tva_pkg::ST_COMMIT;
				end
			end
			tva_pkg::ST_COMMIT: begin
				if (slot_free) begin
					state_d = tva_pkg::ST_IDLE;
				end
			end
			default: state_d = tva_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = (state_q == tva_pkg::ST_IDLE);
		rd_en    = (state_q == tva_pkg::ST_SWEEP) && !rd_done;
		commit   = (state_q == tva_pkg::ST_COMMIT) && slot_free;
	end

	// aging of the entry returned by the memory
	assign cur_time = ram_rdata[TW-1:0];
	assign cur_resv = ram_rdata[TW];
	assign dec_time = (cur_time < item_q.wait_time) ? '0 : cur_time - item_q.wait_time;

	// voice choice at commit
	always_comb begin
		prior_w   = PW'(item_q.prior_voice);
		cont_ok   = item_q.continues_voice && (prior_w < PW'(count_q));
		fresh     = 1'b0;
		full      = 1'b0;
		voice     = '0;
		keep_time = '0;
		count_d   = count_q;
		priority if (cont_ok) begin
			voice     = VW'(item_q.prior_voice);
			keep_time = prior_time_q;
		end else if (found_q) begin
			voice = found_idx_q;
		end else if (count_q != MAX_CNT) begin
			voice   = count_q[VW-1:0];
			fresh   = 1'b1;
			count_d = count_q + CW'(1);
		end else begin
			full = 1'b1;
		end
	end

	// one write port: sweep write-back, else the commit update
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = {cur_resv, dec_time};
		if (vld_s1) begin
			ram_we = 1'b1;
		end else if (commit && !full) begin
			ram_we    = 1'b1;
			ram_waddr = voice;
			ram_wdata = {item_q.reserved_later,
				item_q.loads_graph ? item_q.graph_time : keep_time};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tva_pkg::ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (in_valid && in_ready) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (vld_s1 && !found_q && !cur_resv && (dec_time == '0)) begin
				found_q <= 1'b1;
			end
			if (commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q       <= in_data;
			prior_time_q <= '0;
		end
		if (rd_en) begin
			addr_s1 <= rd_idx_q[VW-1:0];
		end
		if (vld_s1) begin
			if (!found_q) begin
				found_idx_q <= addr_s1;
			end
			if (PW'(addr_s1) == PW'(item_q.prior_voice)) begin
				prior_time_q <= dec_time;
			end
		end
		if (commit) begin
			out_q.assigned_voice <= full ? '0 : tva_pkg::VOICE_W'(voice);
			out_q.fresh_voice    <= fresh;
			out_q.table_full     <= full;
			out_q.voices_in_use  <= tva_pkg::COUNT_W'(count_d);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- tb/tb_timed_voice_allocator_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timed_voice_allocator_unit
// Self-checking bench for the timed voice allocator. A table of event words
// walks through table growth, reuse after aging, continuation and the full
// table. A random part then drives reserve-then-continue chains and stray
// words. Typed rows are checked against their given results, others against
// an in-bench table model, with random idling on both channels in most phases.
// ----------------------------------------------------------------------------
module tb_timed_voice_allocator_unit;

	localparam int NV             = tva_pkg::MAX_VOICES_DEF;
	localparam int TW             = tva_pkg::TIME_W;
	localparam int VW             = tva_pkg::VOICE_W;
	localparam int CW             = tva_pkg::COUNT_W;
	localparam int RAND_PER_PHASE = 510;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int DRAIN_CYCLES   = NV + 8;
	localparam int T_MAX          = 32'h7FFF_FFFF;

	typedef struct {
		tva_pkg::in_word_t  stim;
		tva_pkg::out_word_t want;
		bit                 typed;
		int                 reps;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	tva_pkg::in_word_t  in_data;
	logic               out_valid;
	logic               out_ready = 1'b0;
	tva_pkg::out_word_t out_data;

	// model of the voice table
	logic [TW-1:0] age_left [NV];
	bit            keep_mark [NV];
	int            used_voices;

	tva_pkg::out_word_t pending_alloc [$];
	plan_row_t          plan [$];
	int                 tx_idle;
	int                 rx_idle;
	int                 mismatch_count = 0;
	int                 result_count = 0;
	int                 cycle_count = 0;

	timed_voice_allocator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic tva_pkg::in_word_t ev(input int wt, input int cont,
			input int prior, input int resv, input int graph, input int gt);
		tva_pkg::in_word_t w;
		w.wait_time       = TW'(wt);
		w.continues_voice = (cont != 0);
		w.prior_voice     = VW'(prior);
		w.reserved_later  = (resv != 0);
		w.loads_graph     = (graph != 0);
		w.graph_time      = TW'(gt);
		return w;
	endfunction

	function automatic tva_pkg::out_word_t res(input int voice, input int fresh,
			input int full, input int count);
		tva_pkg::out_word_t r;
		r.assigned_voice = VW'(voice);
		r.fresh_voice    = (fresh != 0);
		r.table_full     = (full != 0);
		r.voices_in_use  = CW'(count);
		return r;
	endfunction

	// ages every allocated voice, then picks one for the event
	function automatic tva_pkg::out_word_t allocate_voice(input tva_pkg::in_word_t w);
		tva_pkg::out_word_t r;
		int                 v;
		int                 pick;
		r    = '0;
		pick = -1;
		for (v = 0; v < used_voices; v++) begin
			if (age_left[v] < w.wait_time)
				age_left[v] = '0;
			else
				age_left[v] = age_left[v] - w.wait_time;
		end
		if (w.continues_voice && int'(w.prior_voice) < used_voices) begin
			pick = int'(w.prior_voice);
		end else begin
			for (v = 0; v < used_voices && pick < 0; v++)
				if (!keep_mark[v] && age_left[v] == '0)
					pick = v;
			if (pick < 0 && used_voices < NV) begin
				pick            = used_voices;
				age_left[pick]  = '0;
				keep_mark[pick] = 1'b0;
				used_voices++;
				r.fresh_voice = 1'b1;
			end
		end
		if (pick < 0) begin
			r.table_full = 1'b1;
		end else begin
			keep_mark[pick] = w.reserved_later;
			if (w.loads_graph)
				age_left[pick] = w.graph_time;
			r.assigned_voice = VW'(pick);
		end
		r.voices_in_use = CW'(used_voices);
		return r;
	endfunction

	// reserve/continue chains over the current table and some stray words
	function automatic tva_pkg::in_word_t next_event();
		tva_pkg::in_word_t w;
		int                held [$];
		int                v;
		int                roll;
		for (v = 0; v < used_voices; v++)
			if (keep_mark[v])
				held.push_back(v);
		roll = $urandom_range(99);
		if (roll < 5)
			w.wait_time = TW'($urandom);
		else if (roll < 15)
			w.wait_time = '0;
		else
			w.wait_time = TW'($urandom_range(40));
		roll = $urandom_range(99);
		if (roll < 40 && held.size() != 0) begin
			w.continues_voice = 1'b1;
			w.prior_voice     = VW'(held[$urandom_range(held.size() - 1)]);
		end else if (roll < 50) begin
			w.continues_voice = 1'b1;
			w.prior_voice     = VW'($urandom_range(63));
		end else begin
			w.continues_voice = 1'b0;
			w.prior_voice     = VW'($urandom_range(63));
		end
		w.reserved_later = ($urandom_range(99) < 35);
		w.loads_graph    = ($urandom_range(99) < 75);
		if ($urandom_range(99) < 5)
			w.graph_time = TW'($urandom);
		else
			w.graph_time = TW'($urandom_range(300));
		return w;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at result %0d: %s", result_count, msg);
		mismatch_count++;
	endtask

	// valid stays up across back-to-back words; it only drops for an idle gap
	task automatic send_event(input tva_pkg::in_word_t w, input bit typed,
			input tva_pkg::out_word_t want);
		tva_pkg::out_word_t guess;
		if (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		guess = allocate_voice(w);
		pending_alloc.push_back(typed ? want : guess);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_alloc.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		tva_pkg::out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_alloc.size() == 0) begin
				flag_mismatch($sformatf("unexpected word %h", out_data));
			end else begin
				want = pending_alloc.pop_front();
				if (out_data.assigned_voice !== want.assigned_voice)
					flag_mismatch($sformatf("assigned_voice got %0d want %0d",
						out_data.assigned_voice, want.assigned_voice));
				if (out_data.fresh_voice !== want.fresh_voice)
					flag_mismatch($sformatf("fresh_voice got %b want %b",
						out_data.fresh_voice, want.fresh_voice));
				if (out_data.table_full !== want.table_full)
					flag_mismatch($sformatf("table_full got %b want %b",
						out_data.table_full, want.table_full));
				if (out_data.voices_in_use !== want.voices_in_use)
					flag_mismatch($sformatf("voices_in_use got %0d want %0d",
						out_data.voices_in_use, want.voices_in_use));
			end
			result_count++;
		end
		out_ready <= (rx_idle == 0) || ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int r;
		int k;
		int ph;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		tx_idle     = 32;
		rx_idle     = 48;
		used_voices = 0;
		for (k = 0; k < NV; k++) begin
			age_left[k]  = '0;
			keep_mark[k] = 1'b0;
		end

		// first voice, then a continuation of a voice that does not exist yet
		plan.push_back('{ev(0, 0, 0, 0, 1, T_MAX), res(0, 1, 0, 1), 1'b1, 1});
		plan.push_back('{ev(0, 1, 63, 1, 0, 0), res(1, 1, 0, 2), 1'b1, 1});
		// huge wait ages voice 0 out, so it is reused
		plan.push_back('{ev(T_MAX, 0, 0, 0, 1, 5), res(0, 0, 0, 2), 1'b1, 1});
		plan.push_back('{ev(0, 1, 1, 0, 1, T_MAX), res(1, 0, 0, 2), 1'b1, 1});
		plan.push_back('{ev(3, 0, 0, 0, 1, 100), res(2, 1, 0, 3), 1'b1, 1});
		// fill the table with reserved voices
		plan.push_back('{ev(0, 0, 0, 1, 1, T_MAX), '0, 1'b0, NV - 3});
		// full; aging still runs on a full event, so voice 0 frees on the second wait
		plan.push_back('{ev(0, 0, 0, 0, 0, 0), res(0, 0, 1, 64), 1'b1, 1});
		plan.push_back('{ev(1, 0, 0, 0, 0, 0), res(0, 0, 1, 64), 1'b1, 1});
		plan.push_back('{ev(1, 0, 0, 0, 0, 0), res(0, 0, 0, 64), 1'b1, 1});
		plan.push_back('{ev(0, 1, 63, 0, 0, 0), res(63, 0, 0, 64), 1'b1, 1});
		plan.push_back('{ev(0, 0, 0, 1, 1, 7), res(0, 0, 0, 64), 1'b1, 1});
		plan.push_back('{ev(6, 0, 0, 0, 0, 0), res(0, 0, 1, 64), 1'b1, 1});
		// everything ages out; voice 0 is still held, so voice 1 is taken
		plan.push_back('{ev(T_MAX, 0, 0, 0, 1, 0), res(1, 0, 0, 64), 1'b1, 1});
		plan.push_back('{ev(0, 1, 0, 0, 0, 0), res(0, 0, 0, 64), 1'b1, 1});
		plan.push_back('{ev('h5555_5555, 0, 21, 1, 1, 'h2AAA_AAAA), '0, 1'b0, 1});
		plan.push_back('{ev('h2AAA_AAAA, 1, 42, 0, 1, 'h5555_5555), '0, 1'b0, 1});
		plan.push_back('{ev(0, 1, 42, 1, 0, T_MAX), '0, 1'b0, 1});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			for (r = 0; r < plan[i].reps; r++)
				send_event(plan[i].stim, plan[i].typed, plan[i].want);
		wait_drained();

		for (ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 32 : (ph == 1) ? 48 : 0;
			rx_idle = (ph == 0) ? 48 : (ph == 1) ? 32 : 0;
			for (k = 0; k < RAND_PER_PHASE; k++)
				send_event(next_event(), 1'b0, '0);
			// hold off the sender until the pipe is empty
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
